// ===== src/imu_fr_pkg.sv =====
// Package for the IMU frame receiver: types, constants and the checksum add.
`timescale 1ns / 1ps

package imu_fr_pkg;

    // Frame geometry
    localparam int FRAME_BYTES_DEF = 20;
    localparam int STORE_DEPTH     = 16;
    localparam int STORE_FIRST     = 2;
    localparam int STORE_AW        = $clog2(STORE_DEPTH);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_MAX_BAD     = 2'd2
    } cfg_idx_t;

    // Register reset values
    localparam logic [7:0] SYNC_FIRST_RST  = 8'h5A;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hA5;
    localparam logic [3:0] MAX_BAD_RST     = 4'd1;

    // Checksum
    localparam logic [15:0] SUM_GOOD = 16'hFFFF;
    localparam logic [3:0]  BAD_SAT  = 4'd15;

    // Write into the payload store
    typedef struct packed {
        logic                wr_en;
        logic [STORE_AW-1:0] wr_addr;
        logic [7:0]          wr_data;
    } store_wr_t;

    // Frame result status from the controller
    typedef struct packed {
        logic done;
        logic good;
        logic lost;
    } frame_res_t;

    // Fields of one frame
    typedef struct packed {
        logic signed [15:0] accel_a;
        logic signed [15:0] accel_b;
        logic signed [15:0] accel_c;
        logic signed [15:0] rate_a;
        logic signed [15:0] rate_b;
        logic signed [15:0] rate_c;
        logic [31:0]        stamp;
    } frame_fields_t;

    // Ones' complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

// ===== src/imu_fr_ctrl.sv =====
// Sync hunt, frame byte counter, running checksum and bad-frame counter.
`timescale 1ns / 1ps

module imu_fr_ctrl
    import imu_fr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic [7:0]            byte_in,
    output store_wr_t             st_wr,
    output frame_res_t            res
);

    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam int CMP_W = 6;
    localparam logic [CMP_W-1:0] LAST_POS  = CMP_W'(FRAME_BYTES - 1);
    localparam logic [CMP_W-1:0] ST_LO     = CMP_W'(STORE_FIRST);
    localparam logic [CMP_W-1:0] ST_HI     = CMP_W'(STORE_FIRST + STORE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_AFTER = IDX_W'(STORE_FIRST);

    typedef enum logic [1:0] {
        PH_HUNT1 = 2'd0,
        PH_HUNT2 = 2'd1,
        PH_SYNC  = 2'd2
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       hold_reg, hold_next;
    logic [3:0]       bad_reg, bad_next;
    logic [7:0]       sync_first_reg, sync_second_reg;
    logic [3:0]       max_bad_reg;

    logic [CMP_W-1:0] idx6;
    logic             is_last;
    logic             is_odd;
    logic [15:0]      word;
    logic [15:0]      sum_add;
    logic [3:0]       bad_inc;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            max_bad_reg     <= MAX_BAD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data[7:0];
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data[7:0];
                CFG_MAX_BAD:     max_bad_reg     <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    // Byte position decode
    assign idx6    = CMP_W'(idx_reg);
    assign is_last = (idx6 >= LAST_POS);
    assign is_odd  = idx_reg[0];
    assign word    = is_odd ? {byte_in, hold_reg} : {8'd0, byte_in};
    assign sum_add = oc_add(sum_reg, word);
    assign bad_inc = (bad_reg < BAD_SAT) ? bad_reg + 4'd1 : BAD_SAT;

    // Store write for payload bytes
    always_comb
    begin
        st_wr.wr_en   = accept && (phase_reg == PH_SYNC) && (idx6 >= ST_LO) && (idx6 < ST_HI);
        st_wr.wr_addr = STORE_AW'(idx6 - ST_LO);
        st_wr.wr_data = byte_in;
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        hold_next  = hold_reg;
        bad_next   = bad_reg;
        res.done   = 1'b0;
        res.good   = 1'b0;
        res.lost   = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT2:
                begin
                    if (byte_in == sync_second_reg)
                    begin
                        sum_next   = {byte_in, hold_reg};
                        idx_next   = IDX_AFTER;
                        bad_next   = 4'd0;
                        phase_next = PH_SYNC;
                    end
                    else
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_SYNC:
                begin
                    if (!is_odd)
                    begin
                        hold_next = byte_in;
                    end
                    if (!is_last)
                    begin
                        idx_next = IDX_W'(idx6 + CMP_W'(1));
                        if (is_odd)
                        begin
                            sum_next = sum_add;
                        end
                    end
                    else
                    begin
                        idx_next = '0;
                        sum_next = 16'd0;
                        res.done = 1'b1;
                        if (sum_add == SUM_GOOD)
                        begin
                            res.good = 1'b1;
                            bad_next = 4'd0;
                        end
                        else
                        begin
                            bad_next = bad_inc;
                            if (bad_inc > max_bad_reg)
                            begin
                                res.lost   = 1'b1;
                                phase_next = PH_HUNT1;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT1;
                    if (byte_in == sync_first_reg)
                    begin
                        hold_next  = byte_in;
                        phase_next = PH_HUNT2;
                    end
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            idx_reg   <= '0;
            sum_reg   <= 16'd0;
            hold_reg  <= 8'd0;
            bad_reg   <= 4'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            hold_reg  <= hold_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

// ===== src/imu_fr_store.sv =====
// Payload byte store and big-endian field assembly with write bypass.
`timescale 1ns / 1ps

module imu_fr_store
    import imu_fr_pkg::*;
(
    input  logic          clk,
    input  store_wr_t     st_wr,
    output frame_fields_t fields
);

    logic [7:0] mem_reg [STORE_DEPTH];
    logic [7:0] view [STORE_DEPTH];

    // Store write, no reset
    always_ff @(posedge clk)
    begin
        if (st_wr.wr_en)
        begin
            mem_reg[st_wr.wr_addr] <= st_wr.wr_data;
        end
    end

    // Entries as seen after this cycle's write
    always_comb
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            view[i] = (st_wr.wr_en && (st_wr.wr_addr == STORE_AW'(i))) ? st_wr.wr_data
                                                                       : mem_reg[i];
        end
    end

    // Big-endian fields
    assign fields.accel_a = {view[0],  view[1]};
    assign fields.accel_b = {view[2],  view[3]};
    assign fields.accel_c = {view[4],  view[5]};
    assign fields.rate_a  = {view[6],  view[7]};
    assign fields.rate_b  = {view[8],  view[9]};
    assign fields.rate_c  = {view[10], view[11]};
    assign fields.stamp   = {view[12], view[13], view[14], view[15]};

endmodule

// ===== src/imu_fr_outreg.sv =====
// Result register: holds one frame result until it is taken.
`timescale 1ns / 1ps

module imu_fr_outreg
    import imu_fr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  frame_res_t    res,
    input  frame_fields_t fields,
    input  logic          frame_stall,
    output logic          frame_valid,
    output logic          frame_good,
    output logic          lost_sync,
    output frame_fields_t fields_out
);

    logic          valid_reg;
    logic          good_reg;
    logic          lost_reg;
    frame_fields_t fields_reg;

    // Valid flag: set on a new result, cleared when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res.done)
        begin
            valid_reg <= 1'b1;
        end
        else if (!frame_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload; bad frames carry zero fields
    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            good_reg   <= res.good;
            lost_reg   <= res.lost;
            fields_reg <= res.good ? fields : '0;
        end
    end

    assign frame_valid = valid_reg;
    assign frame_good  = good_reg;
    assign lost_sync   = lost_reg;
    assign fields_out  = fields_reg;

endmodule

// ===== src/imu_frame_receiver.sv =====
// Top level of the IMU frame receiver.
//
//  channel   dir  handshake                  payload
//  byte      in   byte_valid / byte_stall    byte_in
//  frame     out  frame_valid / frame_stall  frame_good, lost_sync, accel_*, rate_*, stamp
//  config    in   cfg_we                     cfg_index, cfg_data
//
// One byte is taken per cycle; a result appears in the output register the cycle after
// the last byte of a frame and stays until taken. Reset is asynchronous; the payload
// store has no reset and is filled by the frames themselves. byte_stall rises only while
// a result waits and frame_stall is high, so bytes keep flowing while the result is read.
`timescale 1ns / 1ps

module imu_frame_receiver
    import imu_fr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  logic [7:0]            byte_in,
    output logic                  frame_valid,
    input  logic                  frame_stall,
    output logic                  frame_good,
    output logic                  lost_sync,
    output logic signed [15:0]    accel_a,
    output logic signed [15:0]    accel_b,
    output logic signed [15:0]    accel_c,
    output logic signed [15:0]    rate_a,
    output logic signed [15:0]    rate_b,
    output logic signed [15:0]    rate_c,
    output logic [31:0]           stamp
);

    logic          accept;
    store_wr_t     st_wr;
    frame_res_t    res;
    frame_fields_t fields;
    frame_fields_t fields_out;

    // Input handshake
    assign byte_stall = frame_valid && frame_stall;
    assign accept     = byte_valid && !byte_stall;

    imu_fr_ctrl #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .byte_in   (byte_in),
        .st_wr     (st_wr),
        .res       (res)
    );

    imu_fr_store u_store (
        .clk    (clk),
        .st_wr  (st_wr),
        .fields (fields)
    );

    imu_fr_outreg u_outreg (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (res),
        .fields      (fields),
        .frame_stall (frame_stall),
        .frame_valid (frame_valid),
        .frame_good  (frame_good),
        .lost_sync   (lost_sync),
        .fields_out  (fields_out)
    );

    assign accel_a = fields_out.accel_a;
    assign accel_b = fields_out.accel_b;
    assign accel_c = fields_out.accel_c;
    assign rate_a  = fields_out.rate_a;
    assign rate_b  = fields_out.rate_b;
    assign rate_c  = fields_out.rate_c;
    assign stamp   = fields_out.stamp;

endmodule
